### rtl/vfcm_pkg.sv
package vfcm_pkg;

	localparam int unsigned IDX_W  = 17;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned HALF_W = 12;
	localparam int unsigned NFACES = 6;
	localparam logic [HALF_W-1:0] HALF_RESET = 12'd8;

	typedef enum logic [2:0] {
		FACE_FRONT  = 3'd0,
		FACE_BACK   = 3'd1,
		FACE_LEFT   = 3'd2,
		FACE_RIGHT  = 3'd3,
		FACE_TOP    = 3'd4,
		FACE_BOTTOM = 3'd5
	} face_t;

	typedef enum logic [1:0] {
		CORNER_0 = 2'd0,
		CORNER_1 = 2'd1,
		CORNER_2 = 2'd2,
		CORNER_3 = 2'd3
	} corner_t;

	typedef struct packed {
		logic                      chunk_start;
		logic [7:0]                voxel_kind;
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
		logic signed [COORD_W-1:0] centre_z;
		logic [NFACES-1:0]         neighbour_solid;
	} voxel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vert_x;
		logic signed [COORD_W-1:0] vert_y;
		logic signed [COORD_W-1:0] vert_z;
		logic [IDX_W-1:0]          vertex_number;
		logic [2:0]                face_dir;
		logic [1:0]                corner_num;
		logic                      tri_valid;
		logic [IDX_W-1:0]          tri_a;
		logic [IDX_W-1:0]          tri_b;
		logic [IDX_W-1:0]          tri_c;
		logic                      last;
	} vertex_t;

	// classified voxel: which faces still have to be emitted
	typedef struct packed {
		logic                      chunk_start;
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
		logic signed [COORD_W-1:0] centre_z;
		logic [NFACES-1:0]         faces;
	} desc_t;

	// corner sign per face and corner, bit 0 x, bit 1 y, bit 2 z; 1 means plus
	function automatic logic [2:0] corner_sign(input face_t f, input corner_t k);
		logic [2:0] s;
		s = 3'b000;
		case ({f, k})
			{FACE_FRONT, CORNER_0}:  s = 3'b010;
			{FACE_FRONT, CORNER_1}:  s = 3'b011;
			{FACE_FRONT, CORNER_2}:  s = 3'b001;
			{FACE_FRONT, CORNER_3}:  s = 3'b000;
			{FACE_BACK, CORNER_0}:   s = 3'b111;
			{FACE_BACK, CORNER_1}:   s = 3'b110;
			{FACE_BACK, CORNER_2}:   s = 3'b100;
			{FACE_BACK, CORNER_3}:   s = 3'b101;
			{FACE_LEFT, CORNER_0}:   s = 3'b110;
			{FACE_LEFT, CORNER_1}:   s = 3'b010;
			{FACE_LEFT, CORNER_2}:   s = 3'b000;
			{FACE_LEFT, CORNER_3}:   s = 3'b100;
			{FACE_RIGHT, CORNER_0}:  s = 3'b011;
			{FACE_RIGHT, CORNER_1}:  s = 3'b111;
			{FACE_RIGHT, CORNER_2}:  s = 3'b101;
			{FACE_RIGHT, CORNER_3}:  s = 3'b001;
			{FACE_TOP, CORNER_0}:    s = 3'b110;
			{FACE_TOP, CORNER_1}:    s = 3'b111;
			{FACE_TOP, CORNER_2}:    s = 3'b011;
			{FACE_TOP, CORNER_3}:    s = 3'b010;
			{FACE_BOTTOM, CORNER_0}: s = 3'b000;
			{FACE_BOTTOM, CORNER_1}: s = 3'b001;
			{FACE_BOTTOM, CORNER_2}: s = 3'b101;
			{FACE_BOTTOM, CORNER_3}: s = 3'b100;
			default:                 s = 3'b000;
		endcase
		return s;
	endfunction

	// centre plus or minus half extent, clamped to the 16-bit signed range
	function automatic logic [COORD_W-1:0] corner_coord(
		input logic [COORD_W-1:0] centre,
		input logic [HALF_W-1:0]  half,
		input logic               plus
	);
		logic [COORD_W:0] ce;
		logic [COORD_W:0] he;
		logic [COORD_W:0] s;
		logic [COORD_W-1:0] r;
		ce = {centre[COORD_W-1], centre};
		he = {{(COORD_W+1-HALF_W){1'b0}}, half};
		s  = plus ? ce + he : ce - he;
		if (s[COORD_W] != s[COORD_W-1]) begin
			r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			r = s[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/vfcm_front.sv
module vfcm_front (
	input  vfcm_pkg::voxel_t voxel,
	output vfcm_pkg::desc_t  desc
);

	// empty voxel: no faces; solid voxel: every face whose neighbour is not solid
	always_comb begin
		desc.chunk_start = voxel.chunk_start;
		desc.centre_x    = voxel.centre_x;
		desc.centre_y    = voxel.centre_y;
		desc.centre_z    = voxel.centre_z;
		desc.faces       = (voxel.voxel_kind != 8'd0) ? ~voxel.neighbour_solid
			: {vfcm_pkg::NFACES{1'b0}};
	end

endmodule

### rtl/vfcm_queue.sv
module vfcm_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  vfcm_pkg::desc_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output vfcm_pkg::desc_t rd_data,
	output logic            empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	vfcm_pkg::desc_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/vfcm_back.sv
module vfcm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [vfcm_pkg::HALF_W-1:0]     half_extent,
	input  vfcm_pkg::desc_t                 q_data,
	input  logic                            q_empty,
	output logic                            q_pop,
	output vfcm_pkg::vertex_t               vertex,
	output logic                            empty,
	input  logic                            pop
);

	localparam int unsigned IW = vfcm_pkg::IDX_W;

	vfcm_pkg::desc_t             desc_q;
	logic                        busy_q;
	vfcm_pkg::corner_t           corner_q;
	logic [IW-1:0]               vcnt_q;
	logic                        out_valid_q;
	vfcm_pkg::vertex_t           out_q;

	vfcm_pkg::face_t             face;
	logic [vfcm_pkg::NFACES-1:0] remain;
	logic                        emit;
	logic                        last_now;
	logic                        face_done;
	logic [2:0]                  sgn;
	vfcm_pkg::vertex_t           vtx;

	// lowest pending face goes first
	always_comb begin
		face = vfcm_pkg::FACE_FRONT;
		for (int i = vfcm_pkg::NFACES - 1; i >= 0; i--) begin
			if (desc_q.faces[i]) begin
				face = vfcm_pkg::face_t'(3'(i));
			end
		end
	end

	assign remain    = desc_q.faces & ~(vfcm_pkg::NFACES'(1) << face);
	assign face_done = (corner_q == vfcm_pkg::CORNER_3);
	assign last_now  = face_done && (remain == '0);
	assign emit      = busy_q && (!out_valid_q || pop);
	assign q_pop     = !q_empty && (!busy_q || (emit && last_now));
	assign sgn       = vfcm_pkg::corner_sign(face, corner_q);

	always_comb begin
		vtx.vert_x        = vfcm_pkg::corner_coord(desc_q.centre_x, half_extent, sgn[0]);
		vtx.vert_y        = vfcm_pkg::corner_coord(desc_q.centre_y, half_extent, sgn[1]);
		vtx.vert_z        = vfcm_pkg::corner_coord(desc_q.centre_z, half_extent, sgn[2]);
		vtx.vertex_number = vcnt_q + IW'(corner_q);
		vtx.face_dir      = face;
		vtx.corner_num    = corner_q;
		vtx.tri_valid     = 1'b0;
		vtx.tri_a         = '0;
		vtx.tri_b         = '0;
		vtx.tri_c         = '0;
		vtx.last          = last_now;
		case (corner_q)
			vfcm_pkg::CORNER_1: begin
				vtx.tri_valid = 1'b1;
				vtx.tri_a     = vcnt_q;
				vtx.tri_b     = vcnt_q + IW'(1);
				vtx.tri_c     = vcnt_q + IW'(2);
			end
			vfcm_pkg::CORNER_3: begin
				vtx.tri_valid = 1'b1;
				vtx.tri_a     = vcnt_q;
				vtx.tri_b     = vcnt_q + IW'(2);
				vtx.tri_c     = vcnt_q + IW'(3);
			end
			default: begin
				vtx.tri_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_data;
		end else if (emit && face_done) begin
			desc_q.faces <= remain;
		end
		if (emit) begin
			out_q <= vtx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			corner_q    <= vfcm_pkg::CORNER_0;
			vcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				corner_q <= vfcm_pkg::corner_t'(corner_q + 2'd1);
			end
			if (q_pop) begin
				busy_q <= (q_data.faces != '0);
			end else if (emit && face_done) begin
				busy_q <= (remain != '0);
			end
			// chunk start of the next voxel overrides the face advance
			if (q_pop && q_data.chunk_start) begin
				vcnt_q <= '0;
			end else if (emit && face_done) begin
				vcnt_q <= vcnt_q + IW'(4);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign vertex = out_q;
	assign empty  = !out_valid_q;

endmodule

### rtl/voxel_face_culling_mesher.sv
// Path: a voxel passes through the queue, then the corner sequencer's descriptor register, then
// the result register, before its vertices show on the result ports.
// Throughput: the corner sequencer emits one vertex per cycle while the result side keeps
// popping, 4 per visible face, up to 24 for a fully exposed voxel; an empty or hidden voxel emits none.
// Reset: arst_n clears queue, sequencer, vertex counter and result valid; half_extent is 8.
module voxel_face_culling_mesher #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  vfcm_pkg::voxel_t            voxel,
	output logic                        empty,
	input  logic                        pop,
	output vfcm_pkg::vertex_t           vertex,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [vfcm_pkg::HALF_W-1:0] cfg_data
);

	// Front: classify each voxel into the set of faces it exposes. An empty voxel still
	// travels through, so its chunk start flag reaches the vertex counter in order.
	vfcm_pkg::desc_t               desc;
	vfcm_pkg::desc_t               q_data;
	logic                          q_empty;
	logic                          q_pop;
	logic [vfcm_pkg::HALF_W-1:0]   half_q;

	// Configuration: one register, always ready; user must write only while idle; not enforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= vfcm_pkg::HALF_RESET;
		end else if (cfg_valid) begin
			half_q <= cfg_data;
		end
	end

	vfcm_front u_front (
		.voxel (voxel),
		.desc  (desc)
	);

	// Short queue: lets the input side keep taking items while the sequencer works
	// on earlier voxels and the result side stalls.
	vfcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (desc),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// Back: walk pending faces lowest first, four corners each, into the result register.
	// The next voxel is loaded in the same cycle the last vertex of the current one issues.
	vfcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_extent (half_q),
		.q_data      (q_data),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.vertex      (vertex),
		.empty       (empty),
		.pop         (pop)
	);

	// Face bases are multiples of four, so the low index bits track the corner.
	a_index_corner: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (vertex.vertex_number[1:0] == vertex.corner_num))
		else $error("vertex number does not match corner");

	a_tri_corner: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (vertex.tri_valid == vertex.corner_num[0]))
		else $error("triangle flag on wrong corner");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && vertex.last) |-> (vertex.corner_num == vfcm_pkg::CORNER_3))
		else $error("last flag before the final corner of a face");

	a_face_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (vertex.face_dir != 3'd6 && vertex.face_dir != 3'd7))
		else $error("face direction out of range");

endmodule

### tb/sv/tb_voxel_face_culling_mesher.sv
module tb_voxel_face_culling_mesher;

	// Cycles with no item moved on any port before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 1000;
	// Settle time after the last expected vertex: covers empty or hidden voxels
	// still in the queue or the sequencer.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 58;

	// Corner signs per face and corner: bit 2 x, bit 1 y, bit 0 z; 1 means plus.
	localparam logic [0:5][0:3][2:0] CORNER_SIGN = {
		12'b010_110_100_000,
		12'b111_011_001_101,
		12'b011_010_000_001,
		12'b110_111_101_100,
		12'b011_111_110_010,
		12'b000_100_101_001
	};

	typedef struct packed {
		vfcm_pkg::voxel_t  v;
		logic              pinned;
		vfcm_pkg::vertex_t lead;
	} voxel_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           push;
	logic           full;
	vfcm_pkg::voxel_t  voxel;
	logic           empty;
	logic           pop = 1'b0;
	vfcm_pkg::vertex_t vertex;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [vfcm_pkg::HALF_W-1:0] cfg_data;

	// Hand-typed first vertex of a directed item, riding along with the item.
	logic           pin_on;
	vfcm_pkg::vertex_t pin_vertex;

	// Predictor state.
	logic [vfcm_pkg::HALF_W-1:0] half_model = vfcm_pkg::HALF_RESET;
	logic [vfcm_pkg::IDX_W-1:0]  vertex_count_model = '0;
	vfcm_pkg::vertex_t           pending_vertices[$];

	voxel_row_t     directed_rows[$];
	int unsigned    errors;
	int unsigned    idle_cycles;
	bit             quiet;

	// Pop side pacing.
	int unsigned    pop_stall;
	int unsigned    stretch_left;
	bit             pop_steady;

	voxel_face_culling_mesher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.voxel     (voxel),
		.empty     (empty),
		.pop       (pop),
		.vertex    (vertex),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Gap length: mostly short, now and then long.
	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 14)
			return $urandom_range(1, 2);
		if (roll < 19)
			return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	// Centre plus or minus the half extent, clamped to the signed 16-bit range.
	function automatic logic [vfcm_pkg::COORD_W-1:0] corner_pos(
		input logic signed [vfcm_pkg::COORD_W-1:0] centre, input logic plus);
		int sum;
		sum = plus ? int'(centre) + int'(half_model) : int'(centre) - int'(half_model);
		if (sum > 32767)
			sum = 32767;
		else if (sum < -32768)
			sum = -32768;
		return sum[vfcm_pkg::COORD_W-1:0];
	endfunction

	// Queue the vertices one voxel produces and advance the vertex counter.
	function automatic void mesh_voxel(input vfcm_pkg::voxel_t v, input logic pinned,
		input vfcm_pkg::vertex_t lead);
		vfcm_pkg::vertex_t r;
		logic [2:0] s;
		logic [vfcm_pkg::IDX_W-1:0] base;
		vfcm_pkg::corner_t kc;
		int f;
		int k;
		int first;
		first = pending_vertices.size();
		if (v.chunk_start)
			vertex_count_model = '0;
		if (v.voxel_kind == 8'd0)
			return;
		for (f = 0; f < vfcm_pkg::NFACES; f++) begin
			if (v.neighbour_solid[f])
				continue;
			base = vertex_count_model;
			for (k = 0; k < 4; k++) begin
				kc = vfcm_pkg::corner_t'(k);
				s = CORNER_SIGN[f][k];
				r = '0;
				r.vert_x = corner_pos(v.centre_x, s[2]);
				r.vert_y = corner_pos(v.centre_y, s[1]);
				r.vert_z = corner_pos(v.centre_z, s[0]);
				r.vertex_number = base + k[vfcm_pkg::IDX_W-1:0];
				r.face_dir = f[2:0];
				r.corner_num = kc;
				if (kc == vfcm_pkg::CORNER_1 || kc == vfcm_pkg::CORNER_3) begin
					r.tri_valid = 1'b1;
					r.tri_a = base;
					r.tri_b = base + ((kc == vfcm_pkg::CORNER_1) ? 17'd1 : 17'd2);
					r.tri_c = base + ((kc == vfcm_pkg::CORNER_1) ? 17'd2 : 17'd3);
				end
				pending_vertices = {pending_vertices, r};
			end
			vertex_count_model = base + 17'd4;
		end
		if (pending_vertices.size() > first) begin
			pending_vertices[pending_vertices.size() - 1].last = 1'b1;
			if (pinned)
				pending_vertices[first] = lead;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	function automatic void check_vertex(input vfcm_pkg::vertex_t e, input vfcm_pkg::vertex_t a);
		check_field("vert_x", e.vert_x, a.vert_x);
		check_field("vert_y", e.vert_y, a.vert_y);
		check_field("vert_z", e.vert_z, a.vert_z);
		check_field("vertex_number", e.vertex_number, a.vertex_number);
		check_field("face_dir", e.face_dir, a.face_dir);
		check_field("corner_num", e.corner_num, a.corner_num);
		check_field("tri_valid", e.tri_valid, a.tri_valid);
		check_field("tri_a", e.tri_a, a.tri_a);
		check_field("tri_b", e.tri_b, a.tri_b);
		check_field("tri_c", e.tri_c, a.tri_c);
		check_field("last", e.last, a.last);
	endfunction

	// Sample every port at the rising edge: check the popped vertex first, then
	// predict for a pushed item, then track the register, then the watchdog.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (pop && !empty) begin
				moved = 1'b1;
				if (pending_vertices.size() == 0) begin
					errors++;
					$display("%0t: vertex %0d arrived with none expected (expected none)",
						$time, vertex.vertex_number);
				end else begin
					check_vertex(pending_vertices.pop_front(), vertex);
				end
			end
			if (push && !full) begin
				moved = 1'b1;
				mesh_voxel(voxel, pin_on, pin_vertex);
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				half_model = cfg_data;
			end
		end
		if (moved)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Pop side: random stalls, broken up by stretches where it pops every cycle.
	always @(negedge clk) begin
		if (stretch_left == 0) begin
			stretch_left = $urandom_range(50, 400);
			pop_steady = ($urandom_range(0, 3) == 0);
		end
		stretch_left--;
		if (pop_stall != 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop <= 1'b1;
			if (!pop_steady && $urandom_range(0, 2) == 0)
				pop_stall = gap_len();
		end
	end

	// Offer one item, hold it until taken, and return at the following falling edge
	// with push still high; the next call or a drain decides what push does next.
	task automatic send_voxel(input vfcm_pkg::voxel_t v, input logic pinned,
		input vfcm_pkg::vertex_t lead);
		int unsigned gap;
		gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		voxel <= v;
		pin_on <= pinned;
		pin_vertex <= lead;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	// Drop push, wait out every expected vertex, then let the pipe settle.
	task automatic wait_drain();
		push <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_half(input logic [vfcm_pkg::HALF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_row(input logic cs, input logic [7:0] kind, input int x,
		input int y, input int z, input logic [vfcm_pkg::NFACES-1:0] nb);
		voxel_row_t r;
		r = '0;
		r.v.chunk_start = cs;
		r.v.voxel_kind = kind;
		r.v.centre_x = x[vfcm_pkg::COORD_W-1:0];
		r.v.centre_y = y[vfcm_pkg::COORD_W-1:0];
		r.v.centre_z = z[vfcm_pkg::COORD_W-1:0];
		r.v.neighbour_solid = nb;
		directed_rows = {directed_rows, r};
	endfunction

	// Pin the first vertex of the latest row: corner 0 of face f at vertex index 0.
	function automatic void pin_lead(input int x, input int y, input int z,
		input vfcm_pkg::face_t f);
		voxel_row_t r;
		int unsigned n;
		n = directed_rows.size() - 1;
		r = directed_rows[n];
		r.pinned = 1'b1;
		r.lead.vert_x = x[vfcm_pkg::COORD_W-1:0];
		r.lead.vert_y = y[vfcm_pkg::COORD_W-1:0];
		r.lead.vert_z = z[vfcm_pkg::COORD_W-1:0];
		r.lead.face_dir = f;
		r.lead.corner_num = vfcm_pkg::CORNER_0;
		directed_rows[n] = r;
	endfunction

	function automatic logic [vfcm_pkg::COORD_W-1:0] random_coord();
		logic [vfcm_pkg::COORD_W-1:0] d;
		d = vfcm_pkg::COORD_W'($urandom_range(0, 4200));
		case ($urandom_range(0, 7))
			0: return 16'h7fff - d;
			1: return 16'h8000 + d;
			default: return vfcm_pkg::COORD_W'($urandom);
		endcase
	endfunction

	function automatic vfcm_pkg::voxel_t random_voxel();
		vfcm_pkg::voxel_t v;
		v.chunk_start = ($urandom_range(0, 29) == 0);
		v.voxel_kind = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		v.centre_x = random_coord();
		v.centre_y = random_coord();
		v.centre_z = random_coord();
		case ($urandom_range(0, 7))
			0: v.neighbour_solid = '1;
			1: v.neighbour_solid = '0;
			default: v.neighbour_solid = vfcm_pkg::NFACES'($urandom);
		endcase
		return v;
	endfunction

	initial begin
		voxel_row_t r;
		logic [vfcm_pkg::HALF_W-1:0] half;
		int unsigned p;
		int unsigned i;

		arst_n = 1'b0;
		push = 1'b0;
		voxel = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		pin_on = 1'b0;
		pin_vertex = '0;
		quiet = 1'b0;

		// Directed items at the reset half extent of 8. Pinned rows start a chunk
		// or follow one, so their first vertex is index 0.
		add_row(1'b1, 8'd1, 0, 0, 0, 6'b111110);
		pin_lead(-8, 8, -8, vfcm_pkg::FACE_FRONT);
		add_row(1'b0, 8'd0, 100, -100, 5, 6'b000000);        // empty voxel
		add_row(1'b0, 8'd255, 0, 0, 0, 6'b000000);           // all six faces
		add_row(1'b0, 8'd1, 0, 0, 0, 6'b111111);             // hidden voxel
		add_row(1'b1, 8'd128, 32767, 32767, 32767, 6'b111101);
		pin_lead(32767, 32767, 32767, vfcm_pkg::FACE_BACK);            // clamp high
		add_row(1'b1, 8'd1, -32768, -32768, -32768, 6'b011111);
		pin_lead(-32768, -32768, -32768, vfcm_pkg::FACE_BOTTOM);       // clamp low
		add_row(1'b1, 8'd1, 32767, -32768, 0, 6'b111011);
		pin_lead(32759, -32760, 8, vfcm_pkg::FACE_LEFT);
		add_row(1'b1, 8'd0, 0, 0, 0, 6'b000000);             // chunk start on an empty voxel
		add_row(1'b0, 8'd1, 16, 16, 16, 6'b110111);
		pin_lead(24, 24, 8, vfcm_pkg::FACE_RIGHT);
		add_row(1'b0, 8'd2, 32759, -32760, -1, 6'b101111);   // exactly at the limits
		add_row(1'b0, 8'd3, 21845, -21846, 32512, 6'b101010);
		add_row(1'b0, 8'd4, -21846, 21845, -256, 6'b010101);
		add_row(1'b0, 8'd85, 32760, -32761, 1, 6'b000000);   // one past the limits
		add_row(1'b0, 8'd170, -1, -1, -1, 6'b000000);
		add_row(1'b1, 8'd255, 0, 0, 0, 6'b000000);           // chunk start mid stream
		add_row(1'b0, 8'd0, 0, 0, 0, 6'b111111);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[j]) begin
			r = directed_rows[j];
			send_voxel(r.v, r.pinned, r.lead);
		end
		wait_drain();

		// Random phases, each at its own half extent; every third phase pushes
		// back to back.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: half = '0;
				1: half = '1;
				3: half = 12'd1;
				4: half = 12'd4094;
				7: half = vfcm_pkg::HALF_RESET;
				default: half = vfcm_pkg::HALF_W'($urandom);
			endcase
			write_half(half);
			quiet = (p % 3 == 1);
			for (i = 0; i < PHASE_ITEMS; i++)
				send_voxel(random_voxel(), 1'b0, '0);
			wait_drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
rtl/vfcm_pkg.sv
rtl/vfcm_front.sv
rtl/vfcm_queue.sv
rtl/vfcm_back.sv
rtl/voxel_face_culling_mesher.sv
tb/sv/tb_voxel_face_culling_mesher.sv
